[sv/srt_pkg.sv]
// ----------------------------------------------------------------------------
// srt_pkg
// Shared constants and types of the integer array sorter.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_W       = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
    logic              keep;
  } srt_entry_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_EMIT = 2'b10
  } srt_state_t;

endpackage

[sv/srt_front.sv]
// ----------------------------------------------------------------------------
// srt_front
// Accepts items and marks each one as kept or dropped by the fill of its run.
// ----------------------------------------------------------------------------
module srt_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic                      full,
  input  logic signed [31:0]        value,
  input  logic                      last,
  output logic                      wr_en,
  output srt_pkg::srt_entry_t       wr_entry
);

  logic [srt_pkg::COUNT_W-1:0] count;
  logic [srt_pkg::COUNT_W-1:0] count_next;
  logic                        room;

  always_comb begin
    wr_en          = push && !full;
    room           = count < srt_pkg::COUNT_W'(srt_pkg::MAX_ELEMENTS);
    wr_entry.value = value;
    wr_entry.last  = last;
    wr_entry.keep  = room;
    count_next     = count;
    if (wr_en) begin
      if (last) begin
        count_next = '0;
      end else if (room) begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

[sv/srt_queue.sv]
// ----------------------------------------------------------------------------
// srt_queue
// Short queue of classified items between the front and the sorting cells.
// ----------------------------------------------------------------------------
module srt_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  srt_pkg::srt_entry_t wr_entry,
  output logic                full,
  input  logic                rd_en,
  output logic                rd_valid,
  output srt_pkg::srt_entry_t rd_entry
);

  srt_pkg::srt_entry_t        slots [srt_pkg::QUEUE_DEPTH];
  logic [srt_pkg::QPTR_W-1:0] wr_ptr;
  logic [srt_pkg::QPTR_W-1:0] rd_ptr;
  logic [srt_pkg::QCNT_W-1:0] fill;

  assign full     = fill == srt_pkg::QCNT_W'(srt_pkg::QUEUE_DEPTH);
  assign rd_valid = fill != '0;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[sv/srt_back.sv]
// ----------------------------------------------------------------------------
// srt_back
// Row of sorting cells: inserts one kept item per cycle while items wait, in
// ascending order, then shifts the sorted set out one item per cycle on pop.
// ----------------------------------------------------------------------------
module srt_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  srt_pkg::srt_entry_t q_entry,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic signed [31:0]  sorted_value,
  output logic                final_res,
  output logic                overflow
);

  localparam int N = srt_pkg::MAX_ELEMENTS;

  srt_pkg::srt_state_t       state;
  srt_pkg::srt_state_t       state_next;
  logic [srt_pkg::DATA_W-1:0] cell_val      [N];
  logic [srt_pkg::DATA_W-1:0] cell_val_next [N];
  logic [N-1:0]               cell_vld;
  logic [N-1:0]               cell_vld_next;
  logic [N-1:0]               lt;
  logic                       dropped;
  logic                       dropped_next;
  logic                       ins;
  logic                       shift;

  always_comb begin
    q_pop = q_valid && (state == srt_pkg::ST_LOAD);
    ins   = q_pop && q_entry.keep;
    shift = (state == srt_pkg::ST_EMIT) && pop;

    for (int i = 0; i < N; i++) begin
      lt[i] = !cell_vld[i] || ($signed(q_entry.value) < $signed(cell_val[i]));
    end

    cell_val_next = cell_val;
    cell_vld_next = cell_vld;
    if (shift) begin
      for (int i = 0; i < N - 1; i++) begin
        cell_val_next[i] = cell_val[i+1];
        cell_vld_next[i] = cell_vld[i+1];
      end
      cell_vld_next[N-1] = 1'b0;
    end else if (ins) begin
      if (lt[0]) begin
        cell_val_next[0] = q_entry.value;
      end
      cell_vld_next[0] = 1'b1;
      for (int i = 1; i < N; i++) begin
        if (lt[i]) begin
          cell_val_next[i] = lt[i-1] ? cell_val[i-1] : q_entry.value;
        end
        cell_vld_next[i] = cell_vld[i] | cell_vld[i-1];
      end
    end

    state_next   = state;
    dropped_next = dropped;
    unique case (state)
      srt_pkg::ST_LOAD: begin
        if (q_pop) begin
          if (!q_entry.keep) begin
            dropped_next = 1'b1;
          end
          if (q_entry.last) begin
            state_next = srt_pkg::ST_EMIT;
          end
        end
      end
      srt_pkg::ST_EMIT: begin
        if (pop && !cell_vld[1]) begin
          state_next   = srt_pkg::ST_LOAD;
          dropped_next = 1'b0;
        end
      end
      default: begin
        state_next   = srt_pkg::ST_LOAD;
        dropped_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_val <= cell_val_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= srt_pkg::ST_LOAD;
      cell_vld <= '0;
      dropped  <= 1'b0;
    end else begin
      state    <= state_next;
      cell_vld <= cell_vld_next;
      dropped  <= dropped_next;
    end
  end

  assign empty        = state != srt_pkg::ST_EMIT;
  assign sorted_value = cell_val[0];
  assign final_res    = !cell_vld[1];
  assign overflow     = dropped;

endmodule

[sv/integer_array_sorter_unit.sv]
// ----------------------------------------------------------------------------
// integer_array_sorter_unit
// Collects signed 32-bit items up to the last one and returns them sorted.
// ----------------------------------------------------------------------------
// The front takes one item per cycle into a four-item queue while full is low.
// The sorting cells take one item per cycle from that queue while they load
// and it holds items. After the last item of a set reaches the cells, the
// set comes out in ascending order, one item per cycle while pop is high, and
// the cells take no new item until the final one of the set has been popped;
// the queue keeps accepting meanwhile until it fills. Up to 64 items are kept
// per set; further items are dropped and overflow is high on every result of
// that set.
module integer_array_sorter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] value,
  input  logic               last,
  input  logic               pop,
  output logic               empty,
  output logic signed [31:0] sorted_value,
  output logic               final_res,
  output logic               overflow
);

  logic                wr_en;
  srt_pkg::srt_entry_t wr_entry;
  logic                q_valid;
  logic                q_pop;
  srt_pkg::srt_entry_t q_entry;

  srt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .value    (value),
    .last     (last),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  srt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_entry (q_entry)
  );

  srt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .sorted_value (sorted_value),
    .final_res    (final_res),
    .overflow     (overflow)
  );

  // After the final item of a set is taken, no result is shown in the next cycle.
  a_final_ends_set: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && final_res) |=> empty)
    else $error("result shown right after the final item of a set");

  // A set keeps showing results until its final item is taken.
  a_set_continues: assert property (@(posedge clk) disable iff (rst)
    (!empty && !final_res) |=> !empty)
    else $error("set ended before its final item");

  // The overflow mark is the same on every result of one set.
  a_overflow_steady: assert property (@(posedge clk) disable iff (rst)
    (!empty && $past(!empty)) |-> (overflow == $past(overflow)))
    else $error("overflow changed within a set");

endmodule
